// ===== rtl/assert_macros.svh =====
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising edge outside of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/dnap_pkg.sv =====
package dnap_pkg;

    localparam int POSITION_BITS = 32;
    localparam int WORD_BASES    = 32;
    localparam int WORD_SHIFT    = $clog2(WORD_BASES);
    localparam int INDEX_BITS    = 27;

    typedef logic [7:0]               t_char;
    typedef logic [1:0]               t_code;
    typedef logic [1:0]               t_pack_count;
    typedef logic [7:0]               t_packed;
    typedef logic [WORD_BASES-1:0]    t_word;
    typedef logic [WORD_SHIFT-1:0]    t_word_count;
    typedef logic [INDEX_BITS-1:0]    t_word_index;
    typedef logic [POSITION_BITS-1:0] t_position;

    localparam t_char CASE_FOLD_MASK = 8'hDF;
    localparam t_char CHAR_A = 8'h41;
    localparam t_char CHAR_C = 8'h43;
    localparam t_char CHAR_G = 8'h47;
    localparam t_char CHAR_T = 8'h54;

    localparam t_code CODE_A = 2'd0;
    localparam t_code CODE_C = 2'd1;
    localparam t_code CODE_G = 2'd2;
    localparam t_code CODE_T = 2'd3;

    localparam t_pack_count LAST_IN_BYTE = 2'd3;
    localparam t_word_count LAST_IN_WORD = t_word_count'(WORD_BASES - 1);

    typedef struct packed {
        t_code code;
        logic  bad;
    } t_base;

    // upper-case fold, then map to a 2-bit code; anything else is an exception
    function automatic t_base decode_base(input t_char ch);
        t_char folded;
        t_base res;
        folded   = ch & CASE_FOLD_MASK;
        res.code = CODE_A;
        res.bad  = 1'b0;
        case (folded)
            CHAR_A:  res.code = CODE_A;
            CHAR_C:  res.code = CODE_C;
            CHAR_G:  res.code = CODE_G;
            CHAR_T:  res.code = CODE_T;
            default: res.bad  = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/dnap_if.sv =====
// raw character stream into the block
interface dnap_in_if;
    import dnap_pkg::*;
    logic  valid;
    logic  ready;
    t_char base_char;
    modport source (output valid, output base_char, input ready);
    modport sink   (input valid, input base_char, output ready);
endinterface

// decoded base between the input stage and the packer
interface dnap_base_if;
    import dnap_pkg::*;
    logic  valid;
    logic  ready;
    t_base base;
    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

// packed byte plus optional exception word
interface dnap_out_if;
    import dnap_pkg::*;
    logic        valid;
    logic        ready;
    t_packed     packed_byte;
    logic        exception_valid;
    t_word       exception_word;
    t_word_index word_index;
    modport source (output valid, output packed_byte, output exception_valid,
                    output exception_word, output word_index, input ready);
    modport sink   (input valid, input packed_byte, input exception_valid,
                    input exception_word, input word_index, output ready);
endinterface

// ===== rtl/dnap_decode.sv =====
module dnap_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnap_in_if.sink     i_char,
    dnap_base_if.source o_base
);
    import dnap_pkg::*;

    logic  r_valid;
    t_char r_char;

    assign i_char.ready = !r_valid || o_base.ready;
    assign o_base.valid = r_valid;
    assign o_base.base  = decode_base(r_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_valid <= 1'b1;
        end else if (o_base.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.base_char;
        end
    end

endmodule

// ===== rtl/dnap_pack.sv =====
module dnap_pack (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnap_base_if.sink  i_base,
    dnap_out_if.source o_result
);
    import dnap_pkg::*;

    t_packed     r_pack_shift;
    t_pack_count r_pack_count;
    t_word       r_exc_shift;
    t_word_count r_exc_count;
    t_position   r_position;

    logic        r_out_valid;
    t_packed     r_out_byte;
    logic        r_out_exc_valid;
    t_word       r_out_word;
    t_word_index r_out_index;

    logic        take;
    logic        byte_done;
    logic        word_done;
    logic        word_flag;
    t_packed     n_pack_shift;
    t_word       n_exc_shift;

    assign i_base.ready = !r_out_valid || o_result.ready;
    assign take         = i_base.valid && i_base.ready;

    // four codes or 32 flags fully replace the old contents, so no clearing
    assign n_pack_shift = {r_pack_shift[5:0], i_base.base.code};
    assign n_exc_shift  = {r_exc_shift[WORD_BASES-2:0], i_base.base.bad};
    assign byte_done    = r_pack_count == LAST_IN_BYTE;
    assign word_done    = r_exc_count == LAST_IN_WORD;
    assign word_flag    = word_done && (n_exc_shift != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_shift <= '0;
            r_pack_count <= '0;
            r_exc_shift  <= '0;
            r_exc_count  <= '0;
            r_position   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_pack_shift <= n_pack_shift;
                r_pack_count <= r_pack_count + 1'b1;
                r_exc_shift  <= n_exc_shift;
                r_exc_count  <= r_exc_count + 1'b1;
                r_position   <= r_position + 1'b1;
            end
            if (take && byte_done) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && byte_done) begin
            r_out_byte      <= n_pack_shift;
            r_out_exc_valid <= word_flag;
            r_out_word      <= word_flag ? n_exc_shift : '0;
            r_out_index     <= word_flag ? t_word_index'(r_position >> WORD_SHIFT) : '0;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.packed_byte     = r_out_byte;
    assign o_result.exception_valid = r_out_exc_valid;
    assign o_result.exception_word  = r_out_word;
    assign o_result.word_index      = r_out_index;

endmodule

// ===== rtl/dna_two_bit_packer_with_exceptions_unit.sv =====
// two-bit nucleotide packer: one sequence character per transaction on i_base,
// folded to upper case; A, C, G, T map to codes 0..3 and any other byte maps
// to code 0 and sets its flag in a 32-base exception word (latest base in
// bit 0). every fourth character yields one result transaction on o_result
// holding the packed byte (first base in bits 7..6); on every 32nd character
// the same result also carries the exception word and its word index
// (base position / 32, low 27 bits), with exception_valid high only when the
// word is nonzero, and all exception fields zero otherwise. the base position
// counter wraps at 2^32. the block takes one character per clock cycle while
// o_result is being drained; a character is held in the input register and
// is then folded into the result register, and the result register offers
// each finished result on o_result. the result register frees up for the
// next item in the same cycle it is taken; while a finished result waits
// unaccepted the packer takes nothing, and the input stalls once the input
// register holds a character
`include "assert_macros.svh"

module dna_two_bit_packer_with_exceptions_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnap_in_if.sink    i_base,
    dnap_out_if.source o_result
);
    import dnap_pkg::*;

    // decoded base channel between input register and packer
    dnap_base_if w_base ();

    // input register and character decode
    dnap_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_base),
        .o_base  (w_base.source)
    );

    // packing shifters, counters and result register
    dnap_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_base   (w_base.sink),
        .o_result (o_result)
    );

    // a flagged exception word is never empty
    `ASSERT_RST(a_exc_nonzero, i_clk, i_rst_n, (o_result.valid && o_result.exception_valid) |-> (o_result.exception_word != '0), "exception word flagged but empty")

    // without a flagged word the exception fields are zero
    `ASSERT_RST(a_exc_clear, i_clk, i_rst_n, (o_result.valid && !o_result.exception_valid) |-> (o_result.exception_word == '0 && o_result.word_index == '0), "exception fields not cleared")

    // an accepted character sits in the input register on the next cycle
    `ASSERT_RST(a_in_stage, i_clk, i_rst_n, (i_base.valid && i_base.ready) |=> w_base.valid, "accepted character lost")

endmodule

// ===== dv/dna_two_bit_packer_with_exceptions_unit_tb.sv =====
module dna_two_bit_packer_with_exceptions_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnap_pkg::*;

    // run shape
    localparam int RESET_CYCLES  = 7;
    localparam int PHASE_CHARS   = 270;  // four phases, ~1100 characters with the directed rows
    localparam int BLOCK_CHARS   = 32;   // content style is redrawn every block
    localparam int STALL_LIMIT   = 1000; // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 8;    // input register and result register, plus margin
    localparam int SHOWN_ERRORS  = 10;

    localparam t_char LOWER_CASE = 8'h20;

    // content styles of a random block
    typedef enum int {
        BLOCK_CLEAN,   // only A/C/G/T in random case, exception word stays zero
        BLOCK_SPARSE,  // mostly bases, an odd junk byte here and there
        BLOCK_NOISE    // any byte at all
    } block_style_e;

    // one result transaction as seen on o_result
    typedef struct packed {
        t_packed     packed_val;
        logic        flagged;
        t_word       flags;
        t_word_index word_idx;
    } packer_result_t;

    // directed row: one character, and on the fourth of a byte the packed value typed in
    typedef struct packed {
        t_char   ch;
        bit      typed;
        t_packed packed_val;
    } directed_row_t;

    logic i_clk;
    logic i_rst_n;

    dnap_in_if  base_if ();
    dnap_out_if result_if ();

    dna_two_bit_packer_with_exceptions_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_base   (base_if.sink),
        .o_result (result_if.source)
    );

    // predictor state, mirrors the block after each accepted character
    t_packed     pack_acc;
    t_pack_count pack_fill;
    t_word       flag_acc;
    t_word_count flag_fill;
    t_position   position;

    packer_result_t expected_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int chars_sent;
    int bytes_checked;
    int words_seen;
    int mismatches;
    int quiet_cycles;

    // directed rows: case folding, every base, high-bit and control bytes
    directed_row_t directed_rows[24] = '{
        '{CHAR_A, 1'b0, 8'h00}, '{CHAR_C, 1'b0, 8'h00},
        '{CHAR_G, 1'b0, 8'h00}, '{CHAR_T, 1'b1, 8'h1B},
        '{CHAR_A | LOWER_CASE, 1'b0, 8'h00}, '{CHAR_C | LOWER_CASE, 1'b0, 8'h00},
        '{CHAR_G | LOWER_CASE, 1'b0, 8'h00}, '{CHAR_T | LOWER_CASE, 1'b1, 8'h1B},
        '{CHAR_T, 1'b0, 8'h00}, '{CHAR_T, 1'b0, 8'h00},
        '{CHAR_T, 1'b0, 8'h00}, '{CHAR_T, 1'b1, 8'hFF},
        // zero, all ones, bit 7 alone and an N all code as A
        '{8'h00, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
        '{8'h80, 1'b0, 8'h00}, '{8'h4E, 1'b1, 8'h00},
        // base letters with bit 7 set or bit 6 cleared are junk too
        '{8'hC1, 1'b0, 8'h00}, '{CHAR_A | LOWER_CASE, 1'b0, 8'h00},
        '{8'hE7, 1'b0, 8'h00}, '{8'h14, 1'b1, 8'h00},
        '{8'h7F, 1'b0, 8'h00}, '{CHAR_T, 1'b0, 8'h00},
        '{8'h4E, 1'b0, 8'h00}, '{CHAR_G, 1'b1, 8'h32}
    };

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // advance the packer by one character; returns 1 when a byte completes
    function automatic bit advance_packer(input t_char ch, output packer_result_t res);
        t_char folded;
        t_code code;
        logic  junk;
        t_word word_now;
        bit    byte_done;
        folded = ch & CASE_FOLD_MASK;
        junk   = 1'b0;
        case (folded)
            CHAR_A: code = CODE_A;
            CHAR_C: code = CODE_C;
            CHAR_G: code = CODE_G;
            CHAR_T: code = CODE_T;
            default: begin
                code = CODE_A;
                junk = 1'b1;
            end
        endcase
        res = '0;

        // first base ends up in bits 7..6
        byte_done      = (pack_fill == LAST_IN_BYTE);
        res.packed_val = {pack_acc[5:0], code};
        pack_acc       = byte_done ? '0 : {pack_acc[5:0], code};
        pack_fill      = pack_fill + 1'b1;

        // latest base in bit 0; a clean word is never reported
        word_now = {flag_acc[WORD_BASES-2:0], junk};
        if (flag_fill == LAST_IN_WORD) begin
            if (word_now != '0) begin
                res.flagged  = 1'b1;
                res.flags    = word_now;
                res.word_idx = t_word_index'(position >> WORD_SHIFT);
            end
            flag_acc = '0;
        end else begin
            flag_acc = word_now;
        end
        flag_fill = flag_fill + 1'b1;
        position  = position + 1'b1;
        return byte_done;
    endfunction

    function automatic t_char pick_char(input block_style_e style);
        t_char letter;
        case ($urandom_range(3))
            0: letter = CHAR_A;
            1: letter = CHAR_C;
            2: letter = CHAR_G;
            default: letter = CHAR_T;
        endcase
        if ($urandom_range(1) == 1)
            letter = letter | LOWER_CASE;
        if (style == BLOCK_NOISE || (style == BLOCK_SPARSE && $urandom_range(15) == 0))
            letter = t_char'($urandom_range(255));
        return letter;
    endfunction

    // one input transaction, with a random gap in front of it
    task automatic send_char(input t_char ch, input bit typed, input t_packed typed_val);
        packer_result_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            base_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        base_if.valid     <= 1'b1;
        base_if.base_char <= ch;
        do @(posedge i_clk); while (!base_if.ready);
        chars_sent++;
        if (advance_packer(ch, res)) begin
            // the directed rows carry their packed byte, never an exception word
            if (typed) begin
                res            = '0;
                res.packed_val = typed_val;
            end
            expected_bytes.push_back(res);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("byte %0d %s: expected 0x%0h, got 0x%0h",
                         bytes_checked, what, want, seen);
        end
    endtask

    // receiver: ready redrawn every cycle at the phase's stall rate
    always @(posedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        packer_result_t seen;
        packer_result_t want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            seen = '{result_if.packed_byte, result_if.exception_valid,
                     result_if.exception_word, result_if.word_index};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result transaction: byte 0x%0h", seen.packed_val);
            end else begin
                want = expected_bytes.pop_front();
                check_field("packed_byte", 64'(want.packed_val), 64'(seen.packed_val));
                check_field("exception_valid", 64'(want.flagged), 64'(seen.flagged));
                check_field("exception_word", 64'(want.flags), 64'(seen.flags));
                check_field("word_index", 64'(want.word_idx), 64'(seen.word_idx));
                if (want.flagged)
                    words_seen++;
                bytes_checked++;
            end
        end
    end

    // watchdog: any transaction on either side resets the count
    always @(posedge i_clk) begin
        if ((base_if.valid && base_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("dna_two_bit_packer_with_exceptions_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int           phase_idle[4];
        int           phase_stall[4];
        block_style_e style;
        phase_idle  = '{0, 80, 0, 38};
        phase_stall = '{0, 0, 80, 38};

        // every block input known from time zero
        i_rst_n           = 1'b0;
        base_if.valid     = 1'b0;
        base_if.base_char = '0;
        result_if.ready   = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        chars_sent        = 0;
        bytes_checked     = 0;
        words_seen        = 0;
        mismatches        = 0;
        quiet_cycles      = 0;

        pack_acc  = '0;
        pack_fill = '0;
        flag_acc  = '0;
        flag_fill = '0;
        position  = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, no idling on either side
        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].typed,
                      directed_rows[i].packed_val);

        // random phases: free flow, slow sender, slow receiver, both
        style = BLOCK_CLEAN;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_CHARS; n++) begin
                // mostly clean or lightly spoiled sequence, some pure noise
                if (n % BLOCK_CHARS == 0) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: style = BLOCK_CLEAN;
                        4, 5, 6, 7: style = BLOCK_SPARSE;
                        default:    style = BLOCK_NOISE;
                    endcase
                end
                send_char(pick_char(style), 1'b0, '0);
            end
        end

        // stop sending, let the receiver drain everything
        base_if.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d characters over four flow-control phases", chars_sent);
        $display("checked %0d packed bytes, %0d of them with an exception word",
                 bytes_checked, words_seen);
        if (mismatches == 0) begin
            $display("dna_two_bit_packer_with_exceptions_unit: match");
        end else begin
            $display("dna_two_bit_packer_with_exceptions_unit: mismatch");
        end
        $finish;
    end

endmodule
